// ===== rtl/integer_to_ascii_radix_core_defines.svh =====
// Assertion macros shared by the integer to ASCII radix converter RTL.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define I2AR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2ar assertion failed");
`define I2AR_NEVER(lbl, clk, rstn, cond) \
  `I2AR_ASSERT(lbl, clk, rstn, !(cond))
`else
`define I2AR_ASSERT(lbl, clk, rstn, prop)
`define I2AR_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/i2ar_pkg.sv =====
// Types, constants and character helpers for the integer to ASCII radix converter.
package i2ar_pkg;

  localparam int LongBitsDefault = 64;
  localparam int ValueW          = 64;
  localparam int MaxDigits       = 22;
  localparam int DigW            = 4;
  localparam int DigIdxW         = $clog2(MaxDigits);
  localparam int ErrLen          = 6;
  localparam int ErrIdxW         = $clog2(ErrLen);
  localparam int ConvSteps       = ValueW;
  localparam int QDepth          = 2;

  // mode codes
  localparam logic [2:0] MODE_SDEC  = 3'd0;
  localparam logic [2:0] MODE_UDEC  = 3'd1;
  localparam logic [2:0] MODE_OCT   = 3'd2;
  localparam logic [2:0] MODE_HEXL  = 3'd3;
  localparam logic [2:0] MODE_HEXU  = 3'd4;

  // length codes
  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_LONG  = 2'd1;
  localparam logic [1:0] LEN_LLONG = 2'd2;
  localparam logic [1:0] LEN_BAD   = 2'd3;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] ALPHA_LOWER = 8'h57;
  localparam logic [7:0] ALPHA_UPPER = 8'h37;

  localparam logic [7:0] ERR_TEXT [ErrLen] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h20};

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  mode;
    logic [1:0]  length_code;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic              err;
    logic              neg;
    radix_e            radix;
    logic              upper;
    logic [ValueW-1:0] mag;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [DigW-1:0] d, input logic upper);
    logic [7:0] base;
    base = (d < DigW'(10)) ? CHAR_ZERO : (upper ? ALPHA_UPPER : ALPHA_LOWER);
    return 8'(base + {4'b0, d});
  endfunction

endpackage

// ===== rtl/i2ar_front.sv =====
// Front end: extends the operand by length code, picks radix and forms the magnitude.
module i2ar_front #(
  parameter int LongBits = i2ar_pkg::LongBitsDefault
) (
  input  i2ar_pkg::in_t  item_i,
  output i2ar_pkg::job_t job_o
);

  localparam int LongEff = (LongBits >= 1 && LongBits <= 64) ? LongBits : 64;
  localparam logic [63:0] LongMask =
    (LongEff >= 64) ? {64{1'b1}} : ((64'd1 << LongEff) - 64'd1);

  logic        is_signed;
  logic [63:0] ext;
  logic [63:0] long_masked;

  assign is_signed   = (item_i.mode == i2ar_pkg::MODE_SDEC);
  assign long_masked = item_i.value & LongMask;

  always_comb begin
    unique case (item_i.length_code)
      i2ar_pkg::LEN_INT: begin
        ext = {{32{is_signed & item_i.value[31]}}, item_i.value[31:0]};
      end
      i2ar_pkg::LEN_LONG: begin
        ext = (is_signed && item_i.value[LongEff-1]) ? (long_masked | ~LongMask)
                                                      : long_masked;
      end
      default: begin
        ext = item_i.value;
      end
    endcase
  end

  always_comb begin
    job_o.err   = (item_i.mode > i2ar_pkg::MODE_HEXU) ||
                  (item_i.length_code == i2ar_pkg::LEN_BAD);
    job_o.neg   = is_signed & ext[63];
    job_o.mag   = job_o.neg ? 64'(64'd0 - ext) : ext;
    job_o.upper = (item_i.mode == i2ar_pkg::MODE_HEXU);
    unique case (item_i.mode)
      i2ar_pkg::MODE_OCT:  job_o.radix = i2ar_pkg::RADIX_OCT;
      i2ar_pkg::MODE_HEXL: job_o.radix = i2ar_pkg::RADIX_HEX;
      i2ar_pkg::MODE_HEXU: job_o.radix = i2ar_pkg::RADIX_HEX;
      default:             job_o.radix = i2ar_pkg::RADIX_DEC;
    endcase
  end

endmodule

// ===== rtl/i2ar_fifo.sv =====
// Short job queue between the front end and the conversion back end.
module i2ar_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  i2ar_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output i2ar_pkg::job_t rd_data_o,
  output logic           empty_o
);

  localparam int AddrW = (i2ar_pkg::QDepth > 1) ? $clog2(i2ar_pkg::QDepth) : 1;
  localparam int CntW  = $clog2(i2ar_pkg::QDepth + 1);

  i2ar_pkg::job_t   mem_q [i2ar_pkg::QDepth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(i2ar_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(i2ar_pkg::QDepth - 1)) ? '0 : AddrW'(wr_ptr_q + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(i2ar_pkg::QDepth - 1)) ? '0 : AddrW'(rd_ptr_q + 1'b1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (!do_wr && do_rd) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/i2ar_back.sv =====
// Back end: double-dabble conversion for decimal, leading-zero skip and byte emission.
module i2ar_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  i2ar_pkg::job_t job_i,
  input  logic           job_empty_i,
  output logic           job_pop_o,
  output i2ar_pkg::out_t result_o,
  output logic           empty,
  input  logic           pop
);

  localparam int DigIdxW = i2ar_pkg::DigIdxW;
  localparam int DigW    = i2ar_pkg::DigW;
  localparam int NDig    = i2ar_pkg::MaxDigits;
  localparam int FlatW   = NDig * DigW;
  localparam int CntW    = $clog2(i2ar_pkg::ConvSteps);
  localparam int ErrIdxW = i2ar_pkg::ErrIdxW;
  localparam int OctPadW = 3 * NDig;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [DigIdxW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic                             neg_q, neg_d;
  logic                             upper_q, upper_d;
  logic [i2ar_pkg::ValueW-1:0]      sh_q, sh_d;
  logic [NDig-1:0][DigW-1:0]        dig_q, dig_d;
  logic                             out_valid_q, out_valid_d;
  i2ar_pkg::out_t                   out_q, out_d;

  logic                             can_load;
  logic                             out_load;
  i2ar_pkg::out_t                   out_new;
  logic [NDig-1:0][DigW-1:0]        corr;
  logic [NDig-1:0][DigW-1:0]        oct_dig;
  logic [NDig-1:0][DigW-1:0]        hex_dig;
  logic [OctPadW-1:0]               oct_src;
  logic [DigW-1:0]                  cur_dig;

  assign can_load = ~out_valid_q | pop;
  assign empty    = ~out_valid_q;
  assign result_o = out_q;
  assign cur_dig  = dig_q[idx_q];
  assign oct_src  = OctPadW'(job_i.mag);

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      corr[i] = (dig_q[i] >= DigW'(5)) ? DigW'(dig_q[i] + DigW'(3)) : dig_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      oct_dig[i] = {1'b0, oct_src[3*i +: 3]};
      hex_dig[i] = '0;
    end
    for (int i = 0; i < i2ar_pkg::ValueW / DigW; i++) begin
      hex_dig[i] = job_i.mag[DigW*i +: DigW];
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    upper_d   = upper_q;
    sh_d      = sh_q;
    dig_d     = dig_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    out_new   = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          neg_d     = job_i.neg;
          upper_d   = job_i.upper;
          sh_d      = job_i.mag;
          cnt_d     = '0;
          if (job_i.err) begin
            idx_d   = '0;
            state_d = S_ERR;
          end else begin
            idx_d = DigIdxW'(NDig - 1);
            unique case (job_i.radix)
              i2ar_pkg::RADIX_OCT: begin
                dig_d   = oct_dig;
                state_d = S_SKIP;
              end
              i2ar_pkg::RADIX_HEX: begin
                dig_d   = hex_dig;
                state_d = S_SKIP;
              end
              default: begin
                dig_d   = '0;
                state_d = S_CONV;
              end
            endcase
          end
        end
      end
      S_CONV: begin
        dig_d = FlatW'({corr, sh_q[i2ar_pkg::ValueW-1]});
        sh_d  = {sh_q[i2ar_pkg::ValueW-2:0], 1'b0};
        cnt_d = CntW'(cnt_q + 1'b1);
        if (cnt_q == CntW'(i2ar_pkg::ConvSteps - 1)) begin
          idx_d   = DigIdxW'(NDig - 1);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros; the units digit always goes out
        if (cur_dig == '0 && idx_q != '0) begin
          idx_d = DigIdxW'(idx_q - 1'b1);
        end else begin
          state_d = neg_q ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (can_load) begin
          out_load         = 1'b1;
          out_new.char_out = i2ar_pkg::CHAR_MINUS;
          out_new.last     = 1'b0;
          state_d          = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (can_load) begin
          out_load         = 1'b1;
          out_new.char_out = i2ar_pkg::digit_char(cur_dig, upper_q);
          out_new.last     = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d = DigIdxW'(idx_q - 1'b1);
          end
        end
      end
      S_ERR: begin
        if (can_load) begin
          out_load         = 1'b1;
          out_new.char_out = i2ar_pkg::ERR_TEXT[idx_q[ErrIdxW-1:0]];
          out_new.last     = (idx_q == DigIdxW'(i2ar_pkg::ErrLen - 1));
          if (idx_q == DigIdxW'(i2ar_pkg::ErrLen - 1)) begin
            state_d = S_IDLE;
          end else begin
            idx_d = DigIdxW'(idx_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = out_new;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    upper_q <= upper_d;
    sh_q    <= sh_d;
    dig_q   <= dig_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/integer_to_ascii_radix_core.sv =====
// Integer to ASCII radix converter top level: front end, job queue and back end.
// Flow: decimal items run the 64-step shift loop and then the zero skip; octal or hex items
//   go straight to the zero skip (one leading slot per cycle); error runs emit the error text.
// The back end takes one item at a time and pops the next job only after the last beat of the
//   current one is loaded, a minus beat leading a negative value; result stalls hold it.
// Reset: asynchronous, clears the job queue, the back-end sequencer and the result beat.
`include "integer_to_ascii_radix_core_defines.svh"

module integer_to_ascii_radix_core #(
  parameter int LongBits = i2ar_pkg::LongBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  i2ar_pkg::in_t  item_i,
  output logic           empty,
  input  logic           pop,
  output i2ar_pkg::out_t result_o
);

  i2ar_pkg::job_t front_job;
  i2ar_pkg::job_t q_job;
  logic           q_empty;
  logic           q_pop;

  i2ar_front #(
    .LongBits (LongBits)
  ) u_front (
    .item_i (item_i),
    .job_o  (front_job)
  );

  i2ar_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_job),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_job),
    .empty_o   (q_empty)
  );

  i2ar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .result_o    (result_o),
    .empty       (empty),
    .pop         (pop)
  );

  `I2AR_NEVER(a_no_pop_when_q_empty, clk_i, rst_ni, q_pop && q_empty)
  `I2AR_ASSERT(a_push_fills_q, clk_i, rst_ni, (push && !full) |=> !q_empty)

endmodule
